### design/msrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msrq_pkg
// Shared types and default sizes for the message slot ring queue.
// ----------------------------------------------------------------------------
package msrq_pkg;

	// default geometry
	localparam int DefSlotCount = 8;
	localparam int DefSlotBytes = 16;

	// operation carried by an input beat
	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// result kind
	typedef enum logic [1:0] {
		ST_BYTE   = 2'd0,
		ST_ACCEPT = 2'd1,
		ST_REJECT = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// sequencer states, one-hot
	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_LEN   = 3'b010,
		S_BYTES = 3'b100
	} state_t;

endpackage
`default_nettype wire

### design/message_slot_ring_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// A final push byte shows its result in the cycle after acceptance.
// Pop of an L-byte message: length read, then each byte read from the slot memory
// into a read register, then into the result register; one byte per cycle while the
// result channel is not stalled. Input stalls until the last byte is loaded, and
// longer while the result channel is stalled. Clear and unused modes give no result.
// Reset clears pointers, count, cursor and output valid at once; slot memories are not
// cleared and need no clearing pass (a slot is only read after it is written).
// ----------------------------------------------------------------------------
// message_slot_ring_queue
// Ring of fixed-size message slots held in a byte memory and a length memory.
// ----------------------------------------------------------------------------
module message_slot_ring_queue
	import msrq_pkg::*;
#(
	parameter int SLOT_COUNT = DefSlotCount,
	parameter int SLOT_BYTES = DefSlotBytes,
	localparam int LenW = $clog2(SLOT_BYTES + 1),
	localparam int CntW = $clog2(SLOT_COUNT + 1)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	// input channel
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [1:0]      mode,
	input  wire logic [7:0]      data_byte,
	input  wire logic            last_byte,
	// result channel
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [7:0]           out_byte,
	output logic                 out_last,
	output logic [1:0]           status,
	output logic [LenW-1:0]      msg_length,
	output logic [CntW-1:0]      queued_count
);

	localparam int SlotW = $clog2(SLOT_COUNT);
	localparam int IdxW  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
	localparam int Depth = SLOT_COUNT * SLOT_BYTES;
	localparam int AddrW = $clog2(Depth);

	// storage
	logic [7:0]      byte_mem [Depth];
	logic [LenW-1:0] len_mem  [SLOT_COUNT];

	// control state
	state_t           state_q;
	logic [SlotW-1:0] head_q, tail_q;
	logic [CntW-1:0]  held_q;
	logic [LenW-1:0]  cursor_q;
	logic             overlong_q;

	// pop sequencing
	logic [AddrW-1:0] pop_base_q;
	logic [LenW-1:0]  pop_len_q;
	logic [LenW-1:0]  rd_cnt_q;
	logic [LenW-1:0]  len_rd_q;
	logic             rd_valid_s1;
	logic             rd_last_s1;
	logic [7:0]       rd_byte_s1;

	// output register
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	status_t          status_q;
	logic [LenW-1:0]  out_len_q;
	logic [CntW-1:0]  out_cnt_q;

	// decode
	mode_t            in_mode;
	logic             out_free;
	logic             accept;
	logic             full;
	logic             store_ok;
	logic             flag_nxt;
	logic [LenW-1:0]  cursor_inc;
	logic [SlotW-1:0] tail_nxt, head_nxt;
	logic [AddrW-1:0] wr_addr, rd_addr, head_base;
	logic             do_push, do_pop, do_clear;
	logic             byte_we;
	logic             commit;
	logic             load_byte;
	logic             rd_en;
	logic [LenW-1:0]  rd_cnt_nxt;

	assign in_mode  = mode_t'(mode);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	assign do_push  = accept && (in_mode == MODE_PUSH);
	assign do_pop   = accept && (in_mode == MODE_POP);
	assign do_clear = accept && (in_mode == MODE_CLEAR);

	// push bookkeeping
	assign full       = (held_q == CntW'(SLOT_COUNT));
	assign store_ok   = !full && (cursor_q != LenW'(SLOT_BYTES));
	assign flag_nxt   = overlong_q || !store_ok;
	assign cursor_inc = cursor_q + LenW'(1);
	assign byte_we    = do_push && store_ok;
	assign commit     = do_push && last_byte && !flag_nxt;
	assign tail_nxt   = (tail_q == SlotW'(SLOT_COUNT - 1)) ? '0 : tail_q + SlotW'(1);
	assign head_nxt   = (head_q == SlotW'(SLOT_COUNT - 1)) ? '0 : head_q + SlotW'(1);
	assign wr_addr    = AddrW'(tail_q) * AddrW'(SLOT_BYTES) + AddrW'(cursor_q[IdxW-1:0]);
	assign head_base  = AddrW'(head_q) * AddrW'(SLOT_BYTES);

	// byte read pipeline
	assign load_byte  = rd_valid_s1 && out_free;
	assign rd_en      = (state_q == S_BYTES) && (rd_cnt_q != pop_len_q)
	                    && (!rd_valid_s1 || load_byte);
	assign rd_cnt_nxt = rd_cnt_q + LenW'(1);
	assign rd_addr    = pop_base_q + AddrW'(rd_cnt_q[IdxW-1:0]);

	// slot memories: one write port, registered read
	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[wr_addr] <= data_byte;
		end
		if (rd_en) begin
			rd_byte_s1 <= byte_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			len_mem[tail_q] <= cursor_inc;
		end
		len_rd_q <= len_mem[head_q];
	end

	// ring pointers, count, push cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			held_q     <= '0;
			cursor_q   <= '0;
			overlong_q <= 1'b0;
		end else if (do_clear) begin
			head_q     <= '0;
			tail_q     <= '0;
			held_q     <= '0;
			cursor_q   <= '0;
			overlong_q <= 1'b0;
		end else if (do_push) begin
			if (last_byte) begin
				cursor_q   <= '0;
				overlong_q <= 1'b0;
				if (commit) begin
					tail_q <= tail_nxt;
					held_q <= held_q + CntW'(1);
				end
			end else begin
				overlong_q <= flag_nxt;
				if (store_ok) begin
					cursor_q <= cursor_inc;
				end
			end
		end else if (do_pop && (held_q != '0)) begin
			head_q <= head_nxt;
			held_q <= held_q - CntW'(1);
		end
	end

	// pop sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			rd_cnt_q    <= '0;
			pop_len_q   <= '0;
			pop_base_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (do_pop && (held_q != '0)) begin
						pop_base_q <= head_base;
						state_q    <= S_LEN;
					end
				end
				S_LEN: begin
					pop_len_q <= len_rd_q;
					rd_cnt_q  <= '0;
					state_q   <= S_BYTES;
				end
				S_BYTES: begin
					if (rd_en) begin
						rd_valid_s1 <= 1'b1;
						rd_last_s1  <= (rd_cnt_nxt == pop_len_q);
						rd_cnt_q    <= rd_cnt_nxt;
					end else if (load_byte) begin
						rd_valid_s1 <= 1'b0;
					end
					if (load_byte && rd_last_s1) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					rd_valid_s1 <= 1'b0;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_byte || (do_push && last_byte)
		             || (do_pop && (held_q == '0))) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_byte) begin
			out_byte_q <= rd_byte_s1;
			out_last_q <= rd_last_s1;
			status_q   <= ST_BYTE;
			out_len_q  <= pop_len_q;
			out_cnt_q  <= held_q;
		end else if (do_push && last_byte) begin
			out_byte_q <= '0;
			out_last_q <= 1'b1;
			if (commit) begin
				status_q  <= ST_ACCEPT;
				out_len_q <= cursor_inc;
				out_cnt_q <= held_q + CntW'(1);
			end else begin
				status_q  <= ST_REJECT;
				out_len_q <= '0;
				out_cnt_q <= held_q;
			end
		end else if (do_pop && (held_q == '0)) begin
			out_byte_q <= '0;
			out_last_q <= 1'b1;
			status_q   <= ST_EMPTY;
			out_len_q  <= '0;
			out_cnt_q  <= '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign out_last     = out_last_q;
	assign status       = status_q;
	assign msg_length   = out_len_q;
	assign queued_count = out_cnt_q;

`ifndef SYNTHESIS
	// count never exceeds the ring size
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CntW'(SLOT_COUNT))
		else $error("held count above slot count");

	// push cursor saturates at the slot size
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= LenW'(SLOT_BYTES))
		else $error("push cursor beyond slot size");

	// a pending byte read only exists while streaming
	a_rd_in_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == S_BYTES))
		else $error("byte read pending outside streaming");

	// length fetch is followed by byte streaming in the next cycle
	a_len_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEN) |=> (state_q == S_BYTES))
		else $error("length fetch did not advance");

	// popping a held message always starts the length fetch
	a_pop_start: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && (held_q != '0)) |=> (state_q == S_LEN))
		else $error("pop did not start");
`endif

endmodule
`default_nettype wire
